>>> rtl/assert_macros.svh
// Assertion macros used by the checker of the stretch block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and off while arst_n is low.
`define LSD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and off while arst_n is low.
`define LSD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/lsd_pkg.sv
// Shared widths, codes and the microcode program of the bitmap line stretcher.
package lsd_pkg;

	// Payload widths of the request, result and configuration channels.
	localparam int ADDR_W     = 10;
	localparam int DATA_W     = 8;
	localparam int PIX_W      = 8;
	localparam int COLO_W     = 12;
	localparam int ADV_W      = 13;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	// Register field widths.
	localparam int DIMR_W   = 13;
	localparam int SX_W     = 12;
	localparam int MODE_W   = 2;
	localparam int STRIDE_W = 8;

	// Request kinds.
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_PIXEL = 1'b1;

	// Pixel formats.
	localparam logic [MODE_W-1:0] MODE_PACKED = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PLANAR = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BYTE   = 2'd2;

	// Leftmost pixel of a packed byte sits in the top bit.
	localparam logic [DATA_W-1:0] MSB_BIT = 8'h80;
	localparam logic [2:0]        BIT_IDX_MASK = 3'h7;

	// Register indexes on the configuration channel.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEST_WIDTH   = 3'd0,
		REG_DEST_HEIGHT  = 3'd1,
		REG_SRC_WIDTH    = 3'd2,
		REG_SRC_HEIGHT   = 3'd3,
		REG_SRC_X_START  = 3'd4,
		REG_PIXEL_MODE   = 3'd5,
		REG_MIRROR_X     = 3'd6,
		REG_PLANE_STRIDE = 3'd7
	} reg_idx_t;

	// Micro program counter and its step names.
	typedef logic [2:0] upc_t;
	localparam upc_t UPC_IDLE  = 3'd0;
	localparam upc_t UPC_RD1   = 3'd1;
	localparam upc_t UPC_RD2   = 3'd2;
	localparam upc_t UPC_RD3   = 3'd3;
	localparam upc_t UPC_XSTEP = 3'd4;
	localparam upc_t UPC_YSTEP = 3'd5;
	localparam upc_t UPC_EMIT  = 3'd6;

	// Sequencing condition of a control word.
	typedef enum logic [2:0] {
		COND_NONE  = 3'd0,
		COND_START = 3'd1,
		COND_XSTEP = 3'd2,
		COND_YSTEP = 3'd3,
		COND_EMIT  = 3'd4
	} cond_t;

	// One control word: read issue, plane, condition and two successors.
	typedef struct packed {
		logic       rd_en;
		logic [1:0] plane;
		cond_t      cond;
		upc_t       go_next;
		upc_t       go_alt;
	} uword_t;

	// The microcode program. go_alt is the branch target of a condition.
	function automatic uword_t ucode_rom(input upc_t pc);
		uword_t w;
		case (pc)
			UPC_IDLE:  w = '{rd_en: 1'b1, plane: 2'd0, cond: COND_START,
				go_next: UPC_RD1, go_alt: UPC_XSTEP};
			UPC_RD1:   w = '{rd_en: 1'b1, plane: 2'd1, cond: COND_NONE,
				go_next: UPC_RD2, go_alt: UPC_RD2};
			UPC_RD2:   w = '{rd_en: 1'b1, plane: 2'd2, cond: COND_NONE,
				go_next: UPC_RD3, go_alt: UPC_RD3};
			UPC_RD3:   w = '{rd_en: 1'b1, plane: 2'd3, cond: COND_NONE,
				go_next: UPC_XSTEP, go_alt: UPC_XSTEP};
			UPC_XSTEP: w = '{rd_en: 1'b0, plane: 2'd0, cond: COND_XSTEP,
				go_next: UPC_IDLE, go_alt: UPC_YSTEP};
			UPC_YSTEP: w = '{rd_en: 1'b0, plane: 2'd0, cond: COND_YSTEP,
				go_next: UPC_EMIT, go_alt: UPC_EMIT};
			UPC_EMIT:  w = '{rd_en: 1'b0, plane: 2'd0, cond: COND_EMIT,
				go_next: UPC_IDLE, go_alt: UPC_IDLE};
			default:   w = '{rd_en: 1'b0, plane: 2'd0, cond: COND_NONE,
				go_next: UPC_IDLE, go_alt: UPC_IDLE};
		endcase
		return w;
	endfunction

endpackage

>>> rtl/lsd_if.sv
// Request, result and configuration channel interfaces of the line stretcher.
interface lsd_req_if;
	import lsd_pkg::*;
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [ADDR_W-1:0] byte_addr;
	logic [DATA_W-1:0] byte_data;
	modport source(output valid, req_type, byte_addr, byte_data, input ready);
	modport sink(input valid, req_type, byte_addr, byte_data, output ready);
endinterface

interface lsd_res_if;
	import lsd_pkg::*;
	logic              valid;
	logic              ready;
	logic [PIX_W-1:0]  pixel;
	logic [COLO_W-1:0] dest_column;
	logic              row_end;
	logic [ADV_W-1:0]  src_rows_advance;
	logic              done_res;
	modport source(output valid, pixel, dest_column, row_end, src_rows_advance, done_res,
		input ready);
	modport sink(input valid, pixel, dest_column, row_end, src_rows_advance, done_res,
		output ready);
endinterface

interface lsd_cfg_if;
	import lsd_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/lsd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module lsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/bitmap_line_stretch_dda_core.sv
// Line store write: stored when accepted, if its address is in range. Pixel request: the store is
// read (four planes in four-plane mode), the x error loop steps source columns, then the
// result is offered. A row-ending pixel also steps source rows before its result is offered.
// A waiting result holds the sequencer until it is taken.
// A register write is taken only while idle, restarts the stretch and holds off requests while
// offered and in the cycle after. Reset restores defaults; the line store is not cleared.
module bitmap_line_stretch_dda_core #(
	parameter int LINE_BYTES = 1024,
	parameter int MAX_DIM    = 4096
) (
	input  logic     clk,
	input  logic     arst_n,
	lsd_req_if.sink  req,
	lsd_res_if.source res,
	lsd_cfg_if.sink  cfg
);
	import lsd_pkg::*;

	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int CW0   = (DIM_W > SX_W) ? DIM_W : SX_W;
	localparam int COL_W = CW0 + 3;
	localparam int ERR_W = DIM_W + 3;
	localparam int MAW   = $clog2(LINE_BYTES);
	localparam int EXT_W = ((COL_W > MAW + 1) ? COL_W : MAW + 1) + 1;

	// Saturate a dimension register to 1 .. MAX_DIM.
	function automatic logic [DIM_W-1:0] dim_sat(input logic [DIMR_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (int'(v) > MAX_DIM) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = DIM_W'(v);
		end
		return r;
	endfunction

	// Configuration registers.
	logic [DIMR_W-1:0]   dest_width_q, dest_height_q, src_width_q, src_height_q;
	logic [SX_W-1:0]     src_x_start_q;
	logic [MODE_W-1:0]   pixel_mode_q;
	logic                mirror_x_q;
	logic [STRIDE_W-1:0] plane_stride_q;
	logic                restart_q;

	// Stretch state.
	upc_t                    upc_q;
	logic signed [COL_W-1:0] src_column_q;
	logic signed [ERR_W-1:0] x_err_q, y_err_q;
	logic [DIM_W-1:0]        col_cnt_q, row_cnt_q, rows_left_q, adv_q;
	logic                    finished_q;

	// Store read pipeline and pixel accumulator.
	logic             rd_pend_q, rd_ok_q;
	logic [1:0]       rd_plane_q;
	logic [2:0]       bsel_q;
	logic [PIX_W-1:0] pix_q;

	// Result register.
	logic              res_valid_q;
	logic [PIX_W-1:0]  res_pixel_q;
	logic [COLO_W-1:0] res_col_q;
	logic              res_row_end_q;
	logic [ADV_W-1:0]  res_adv_q;
	logic              res_done_q;

	// Derived values.
	uword_t                  uw;
	logic [DIM_W-1:0]        dw, dh, sw, sh;
	logic signed [ERR_W-1:0] dw_e, dh_e, sw_e, sh_e;
	logic signed [ERR_W-1:0] dw2, dh2, sw2, sh2;
	logic signed [COL_W-1:0] start_col, col_step;
	logic                    req_ready, req_fire, wr_fire, wr_ok, start, cfg_fire, out_free;
	logic [DIM_W-1:0]        col_next, row_next;
	logic                    x_nonneg, y_nonneg, row_done, rows_all, last_row;
	logic [9:0]              plane_off;
	logic [EXT_W-1:0]        col_ext, rd_addr;
	logic                    rd_ok, mode_ok, rd_issue;
	logic [DATA_W-1:0]       rd_byte;
	logic                    bit_hit;
	logic [PIX_W-1:0]        pix_d, pix_cur;
	upc_t                    upc_d;
	logic                    x_step, x_close, emit_pix, y_step, y_close, emit_row;

	// Saturated dimensions and doubled error increments.
	assign dw   = dim_sat(dest_width_q);
	assign dh   = dim_sat(dest_height_q);
	assign sw   = dim_sat(src_width_q);
	assign sh   = dim_sat(src_height_q);
	assign dw_e = $signed(ERR_W'(dw));
	assign dh_e = $signed(ERR_W'(dh));
	assign sw_e = $signed(ERR_W'(sw));
	assign sh_e = $signed(ERR_W'(sh));
	assign dw2  = dw_e + dw_e;
	assign dh2  = dh_e + dh_e;
	assign sw2  = sw_e + sw_e;
	assign sh2  = sh_e + sh_e;

	// First source column of a row and the column step direction.
	assign start_col = mirror_x_q ?
		$signed(COL_W'(sw)) - $signed(COL_W'(src_x_start_q)) - $signed(COL_W'(1)) :
		$signed(COL_W'(src_x_start_q));
	assign col_step = mirror_x_q ? {COL_W{1'b1}} : COL_W'(1);

	// Handshakes. A pending register write has priority over a request.
	assign uw        = ucode_rom(upc_q);
	assign req_ready = (upc_q == UPC_IDLE) && !restart_q && !cfg.valid;
	assign req_fire  = req.valid && req_ready;
	assign wr_fire   = req_fire && (req.req_type == REQ_WRITE);
	assign wr_ok     = EXT_W'(req.byte_addr) < EXT_W'(LINE_BYTES);
	assign start     = req_fire && (req.req_type == REQ_PIXEL) && !finished_q;
	assign cfg_fire  = cfg.valid && cfg.ready;
	assign out_free  = !res_valid_q || res.ready;
	assign req.ready = req_ready;
	assign cfg.ready = (upc_q == UPC_IDLE);

	// Error loop tests.
	assign col_next = col_cnt_q + DIM_W'(1);
	assign row_next = row_cnt_q + DIM_W'(1);
	assign row_done = col_next >= dw;
	assign rows_all = row_next >= dh;
	assign last_row = rows_left_q == DIM_W'(1);
	assign x_nonneg = !x_err_q[ERR_W-1];
	assign y_nonneg = !y_err_q[ERR_W-1];

	// Store address for the plane named by the current control word.
	assign plane_off = (uw.plane[1] ? {1'b0, plane_stride_q, 1'b0} : 10'd0) +
		(uw.plane[0] ? {2'b00, plane_stride_q} : 10'd0);
	assign col_ext = EXT_W'($unsigned(src_column_q));

	always_comb begin
		mode_ok = 1'b1;
		case (pixel_mode_q)
			MODE_PACKED, MODE_PLANAR: rd_addr = (col_ext >> 3) + EXT_W'(plane_off);
			MODE_BYTE:                rd_addr = col_ext;
			default: begin
				rd_addr = col_ext;
				mode_ok = 1'b0;
			end
		endcase
	end

	assign rd_ok    = mode_ok && !src_column_q[COL_W-1] && (rd_addr < EXT_W'(LINE_BYTES));
	assign rd_issue = uw.rd_en && ((uw.cond != COND_START) || start);

	lsd_ram #(
		.WIDTH(DATA_W),
		.DEPTH(LINE_BYTES)
	) u_line_store (
		.clk  (clk),
		.we   (wr_fire && wr_ok),
		.waddr(MAW'(req.byte_addr)),
		.wdata(req.byte_data),
		.re   (rd_issue),
		.raddr(rd_addr[MAW-1:0]),
		.rdata(rd_byte)
	);

	// Fold the returning store byte into the pixel value.
	assign bit_hit = rd_ok_q && ((rd_byte & (MSB_BIT >> (bsel_q & BIT_IDX_MASK))) != '0);

	always_comb begin
		pix_d = pix_q;
		case (pixel_mode_q)
			MODE_PACKED: pix_d = {{(PIX_W-1){1'b0}}, bit_hit};
			MODE_PLANAR: pix_d[rd_plane_q] = pix_q[rd_plane_q] | bit_hit;
			MODE_BYTE:   pix_d = rd_ok_q ? rd_byte : '0;
			default:     pix_d = '0;
		endcase
	end

	assign pix_cur = rd_pend_q ? pix_d : pix_q;

	// Sequencer: next step and datapath strobes from the control word.
	always_comb begin
		upc_d    = upc_q;
		x_step   = 1'b0;
		x_close  = 1'b0;
		emit_pix = 1'b0;
		y_step   = 1'b0;
		y_close  = 1'b0;
		emit_row = 1'b0;
		case (uw.cond)
			COND_START: begin
				if (start) begin
					upc_d = (pixel_mode_q == MODE_PLANAR) ? uw.go_next : uw.go_alt;
				end
			end
			COND_NONE: upc_d = uw.go_next;
			COND_XSTEP: begin
				if (x_nonneg) begin
					x_step = 1'b1;
				end else if (row_done) begin
					x_close = 1'b1;
					upc_d   = uw.go_alt;
				end else if (out_free) begin
					x_close  = 1'b1;
					emit_pix = 1'b1;
					upc_d    = uw.go_next;
				end
			end
			COND_YSTEP: begin
				if (y_nonneg) begin
					y_step = 1'b1;
					if (last_row) begin
						upc_d = uw.go_next;
					end
				end else begin
					y_close = 1'b1;
					upc_d   = uw.go_next;
				end
			end
			COND_EMIT: begin
				if (out_free) begin
					emit_row = 1'b1;
					upc_d    = uw.go_next;
				end
			end
			default: upc_d = UPC_IDLE;
		endcase
	end

	// Configuration registers and restart flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_width_q   <= DIMR_W'(1);
			dest_height_q  <= DIMR_W'(1);
			src_width_q    <= DIMR_W'(1);
			src_height_q   <= DIMR_W'(1);
			src_x_start_q  <= '0;
			pixel_mode_q   <= MODE_PACKED;
			mirror_x_q     <= 1'b0;
			plane_stride_q <= '0;
			restart_q      <= 1'b0;
		end else begin
			restart_q <= cfg_fire;
			if (cfg_fire) begin
				case (cfg.index)
					REG_DEST_WIDTH:   dest_width_q   <= cfg.data[DIMR_W-1:0];
					REG_DEST_HEIGHT:  dest_height_q  <= cfg.data[DIMR_W-1:0];
					REG_SRC_WIDTH:    src_width_q    <= cfg.data[DIMR_W-1:0];
					REG_SRC_HEIGHT:   src_height_q   <= cfg.data[DIMR_W-1:0];
					REG_SRC_X_START:  src_x_start_q  <= cfg.data[SX_W-1:0];
					REG_PIXEL_MODE:   pixel_mode_q   <= cfg.data[MODE_W-1:0];
					REG_MIRROR_X:     mirror_x_q     <= cfg.data[0];
					REG_PLANE_STRIDE: plane_stride_q <= cfg.data[STRIDE_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// Stretch state: step counter, column walk and both error terms.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q        <= UPC_IDLE;
			src_column_q <= '0;
			x_err_q      <= ERR_W'(1);
			y_err_q      <= ERR_W'(1);
			col_cnt_q    <= '0;
			row_cnt_q    <= '0;
			rows_left_q  <= DIM_W'(1);
			adv_q        <= '0;
			finished_q   <= 1'b0;
			rd_pend_q    <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			rd_pend_q <= rd_issue;
			if (restart_q) begin
				upc_q        <= UPC_IDLE;
				src_column_q <= start_col;
				x_err_q      <= sw2 - dw_e;
				y_err_q      <= sh2 - dh_e;
				col_cnt_q    <= '0;
				row_cnt_q    <= '0;
				rows_left_q  <= sh;
				adv_q        <= '0;
				finished_q   <= 1'b0;
			end else begin
				upc_q <= upc_d;
				if (start) begin
					adv_q <= '0;
				end
				// One source column per cycle until the x error goes negative.
				if (x_step) begin
					src_column_q <= src_column_q + col_step;
					x_err_q      <= x_err_q - dw2;
				end
				if (x_close) begin
					x_err_q <= x_err_q + sw2;
					if (row_done) begin
						col_cnt_q    <= '0;
						src_column_q <= start_col;
					end else begin
						col_cnt_q <= col_next;
					end
				end
				// One source row per cycle; running out of rows ends the stretch.
				if (y_step) begin
					adv_q       <= adv_q + DIM_W'(1);
					rows_left_q <= rows_left_q - DIM_W'(1);
					if (last_row) begin
						finished_q <= 1'b1;
					end else begin
						y_err_q <= y_err_q - dh2;
					end
				end
				if (y_close) begin
					y_err_q   <= y_err_q + sh2;
					row_cnt_q <= row_next;
					if (rows_all) begin
						finished_q <= 1'b1;
					end
				end
			end
			// Result valid flag.
			if (emit_pix || emit_row) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Read tags, pixel accumulator and result payload.
	always_ff @(posedge clk) begin
		rd_ok_q    <= rd_ok;
		rd_plane_q <= uw.plane;
		bsel_q     <= src_column_q[2:0];
		if (start) begin
			pix_q <= '0;
		end else if (rd_pend_q) begin
			pix_q <= pix_d;
		end
		if (emit_pix) begin
			res_pixel_q   <= pix_cur;
			res_col_q     <= COLO_W'(col_cnt_q);
			res_row_end_q <= 1'b0;
			res_adv_q     <= '0;
			res_done_q    <= finished_q;
		end else if (emit_row) begin
			res_pixel_q   <= pix_q;
			res_col_q     <= COLO_W'(dw - DIM_W'(1));
			res_row_end_q <= 1'b1;
			res_adv_q     <= ADV_W'(adv_q);
			res_done_q    <= finished_q;
		end
	end

	assign res.valid            = res_valid_q;
	assign res.pixel            = res_pixel_q;
	assign res.dest_column      = res_col_q;
	assign res.row_end          = res_row_end_q;
	assign res.src_rows_advance = res_adv_q;
	assign res.done_res         = res_done_q;

endmodule

>>> rtl/lsd_checker.sv
// Port-level checks of the line stretcher and their bind to the top level.
`include "assert_macros.svh"

module lsd_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      req_ready,
	input logic                      res_valid,
	input logic                      res_ready,
	input logic [lsd_pkg::PIX_W-1:0]  res_pixel,
	input logic [lsd_pkg::COLO_W-1:0] res_dest_column,
	input logic                      res_row_end,
	input logic [lsd_pkg::ADV_W-1:0]  res_src_rows_advance,
	input logic                      res_done_res,
	input logic                      cfg_valid,
	input logic                      cfg_ready
);

	// A stalled result stays offered.
	`LSD_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid, "result dropped while stalled")

	// A stalled result keeps its payload.
	`LSD_ASSERT_NEXT(a_res_stable, res_valid && !res_ready, $stable(res_pixel) && $stable(res_dest_column) && $stable(res_row_end) && $stable(res_src_rows_advance) && $stable(res_done_res), "result changed while stalled")

	// Only a row-ending pixel can report row steps or completion.
	`LSD_ASSERT_SAME(a_mid_row, res_valid && !res_row_end, res_src_rows_advance == '0 && !res_done_res, "mid-row result carries row-end data")

	// A register write restarts the stretch, which holds off requests in the cycle after it is taken.
	`LSD_ASSERT_NEXT(a_cfg_restart, cfg_valid && cfg_ready, !req_ready, "request taken during restart")

endmodule

bind bitmap_line_stretch_dda_core lsd_checker u_lsd_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.req_ready           (req.ready),
	.res_valid           (res.valid),
	.res_ready           (res.ready),
	.res_pixel           (res.pixel),
	.res_dest_column     (res.dest_column),
	.res_row_end         (res.row_end),
	.res_src_rows_advance(res.src_rows_advance),
	.res_done_res        (res.done_res),
	.cfg_valid           (cfg.valid),
	.cfg_ready           (cfg.ready)
);
